### rtl/assert_macros.svh
// Assertion macros shared by the spiral scan RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/sos_pkg.sv
// Shared types, constants and the microcode table of the spiral scan.
// Depends on nothing; used by sos_seq, sos_dp and spiral_order_scan.
package sos_pkg;

  localparam int DIM_W  = 4;          // dimension register width
  localparam int CNT_W  = 7;          // load and result counter width
  localparam int PTR_W  = DIM_W + 1;  // signed row/column pointers and bounds
  localparam int IDX_W  = 3;          // row or column index into the store
  localparam int DATA_W = 32;
  localparam int STEP_W = 4;

  localparam logic signed [PTR_W-1:0] ONE_S  = PTR_W'(1);
  localparam logic signed [PTR_W-1:0] ZERO_S = PTR_W'(0);

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Microprogram steps
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RING   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TOP    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RCHK   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RIGHT  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TURN   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BOTTOM = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LCHK   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LEFT   = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_RING_START,
    OP_C_INC,
    OP_C_DEC,
    OP_R_INC,
    OP_R_DEC,
    OP_SHRINK
  } sos_op_e;

  typedef enum logic [3:0] {
    COND_GO,
    COND_RING_EMPTY,
    COND_C_AT_RIGHT,
    COND_R_PAST_BOTTOM,
    COND_R_AT_BOTTOM,
    COND_THIN,
    COND_C_AT_LEFT,
    COND_R_AT_TOP,
    COND_R_NEXT_TOP
  } sos_cond_e;

  typedef struct packed {
    logic                emit;
    sos_cond_e           cond;
    logic [STEP_W-1:0]   jt;
    logic [STEP_W-1:0]   jf;
    sos_op_e             op_t;
    sos_op_e             op_f;
  } sos_uword_t;

  typedef struct packed {
    logic    emit;
    sos_op_e op;
  } sos_ctrl_t;

  typedef struct packed {
    logic go;
    logic ring_empty;
    logic c_at_right;
    logic r_past_bottom;
    logic r_at_bottom;
    logic thin;
    logic c_at_left;
    logic r_at_top;
    logic r_next_top;
  } sos_status_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;
  } sos_dims_t;

  function automatic sos_uword_t sos_mk(input logic emit, input sos_cond_e cond,
                                        input logic [STEP_W-1:0] jt,
                                        input logic [STEP_W-1:0] jf,
                                        input sos_op_e op_t, input sos_op_e op_f);
    sos_uword_t w;
    w.emit = emit;
    w.cond = cond;
    w.jt   = jt;
    w.jf   = jf;
    w.op_t = op_t;
    w.op_f = op_f;
    return w;
  endfunction

  // Control store: one word per step, branch taken when the condition holds.
  function automatic sos_uword_t sos_rom(input logic [STEP_W-1:0] step);
    sos_uword_t w;
    case (step)
      STEP_IDLE:   w = sos_mk(1'b0, COND_GO, STEP_RING, STEP_IDLE, OP_INIT, OP_NONE);
      STEP_RING:   w = sos_mk(1'b0, COND_RING_EMPTY, STEP_IDLE, STEP_TOP,
                              OP_NONE, OP_RING_START);
      STEP_TOP:    w = sos_mk(1'b1, COND_C_AT_RIGHT, STEP_RCHK, STEP_TOP,
                              OP_R_INC, OP_C_INC);
      STEP_RCHK:   w = sos_mk(1'b0, COND_R_PAST_BOTTOM, STEP_TURN, STEP_RIGHT,
                              OP_NONE, OP_NONE);
      STEP_RIGHT:  w = sos_mk(1'b1, COND_R_AT_BOTTOM, STEP_TURN, STEP_RIGHT,
                              OP_NONE, OP_R_INC);
      STEP_TURN:   w = sos_mk(1'b0, COND_THIN, STEP_RING, STEP_BOTTOM,
                              OP_SHRINK, OP_C_DEC);
      STEP_BOTTOM: w = sos_mk(1'b1, COND_C_AT_LEFT, STEP_LCHK, STEP_BOTTOM,
                              OP_R_DEC, OP_C_DEC);
      STEP_LCHK:   w = sos_mk(1'b0, COND_R_AT_TOP, STEP_RING, STEP_LEFT,
                              OP_SHRINK, OP_NONE);
      STEP_LEFT:   w = sos_mk(1'b1, COND_R_NEXT_TOP, STEP_RING, STEP_LEFT,
                              OP_SHRINK, OP_R_DEC);
      default:     w = sos_mk(1'b0, COND_GO, STEP_IDLE, STEP_IDLE, OP_NONE, OP_NONE);
    endcase
    return w;
  endfunction

endpackage

### rtl/sos_seq.sv
// Microcode sequencer of the spiral scan: step counter, control store, jumps.
// Depends on sos_pkg.
module sos_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sos_pkg::sos_status_t status_i,
  output sos_pkg::sos_ctrl_t   ctrl_o,
  output logic                 busy_o
);
  import sos_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  sos_uword_t        word;
  logic              hit;

  always_comb begin
    word = sos_rom(step_q);
    case (word.cond)
      COND_GO:            hit = status_i.go;
      COND_RING_EMPTY:    hit = status_i.ring_empty;
      COND_C_AT_RIGHT:    hit = status_i.c_at_right;
      COND_R_PAST_BOTTOM: hit = status_i.r_past_bottom;
      COND_R_AT_BOTTOM:   hit = status_i.r_at_bottom;
      COND_THIN:          hit = status_i.thin;
      COND_C_AT_LEFT:     hit = status_i.c_at_left;
      COND_R_AT_TOP:      hit = status_i.r_at_top;
      COND_R_NEXT_TOP:    hit = status_i.r_next_top;
      default:            hit = 1'b0;
    endcase
    step_d      = hit ? word.jt : word.jf;
    ctrl_o.emit = word.emit;
    ctrl_o.op   = hit ? word.op_t : word.op_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign busy_o = (step_q != STEP_IDLE);

endmodule

### rtl/sos_dp.sv
// Datapath of the spiral scan: load counter, element store, ring bounds,
// row/column pointers and the registered result. Depends on sos_pkg.
`include "assert_macros.svh"

module sos_dp #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic signed [31:0]       element_i,
  input  sos_pkg::sos_dims_t       dims_i,
  input  sos_pkg::sos_ctrl_t       ctrl_i,
  output sos_pkg::sos_status_t     status_o,
  output logic signed [31:0]       value_o,
  output logic                     final_res_o,
  output logic                     valid_o
);
  import sos_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0] load_q, load_d, load_inc;
  logic [CNT_W-1:0] emit_cnt_q, emit_cnt_d;
  logic             accept, complete, wr_en, last;

  logic signed [PTR_W-1:0] top_q, bot_q, left_q, right_q, r_q, c_q;
  logic signed [PTR_W-1:0] rows_s, cols_s;
  logic [CNT_W-1:0]        prod, addr_full;
  logic [AW-1:0]           addr;

  logic [DATA_W-1:0] rd_q;
  logic              valid_q, final_q;

  // Load side: one element per accepted transaction
  always_comb begin
    accept   = start_i & ~busy_i;
    load_inc = load_q + CNT_W'(1);
    complete = (load_inc >= dims_i.total);
    wr_en    = accept & (load_q < DEPTH_C);
    load_d   = load_q;
    if (accept) begin
      load_d = complete ? '0 : load_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else begin
      load_q <= load_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[load_q[AW-1:0]] <= element_i;
    end
  end

  // Ring bounds and walk pointers, moved by the microcode op
  assign rows_s = signed'({1'b0, dims_i.rows});
  assign cols_s = signed'({1'b0, dims_i.cols});

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_INIT: begin
        top_q   <= ZERO_S;
        left_q  <= ZERO_S;
        bot_q   <= rows_s - ONE_S;
        right_q <= cols_s - ONE_S;
      end
      OP_RING_START: begin
        r_q <= top_q;
        c_q <= left_q;
      end
      OP_C_INC: c_q <= c_q + ONE_S;
      OP_C_DEC: c_q <= c_q - ONE_S;
      OP_R_INC: r_q <= r_q + ONE_S;
      OP_R_DEC: r_q <= r_q - ONE_S;
      OP_SHRINK: begin
        top_q   <= top_q + ONE_S;
        left_q  <= left_q + ONE_S;
        bot_q   <= bot_q - ONE_S;
        right_q <= right_q - ONE_S;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_comb begin
    status_o.go            = accept & complete;
    status_o.ring_empty    = (left_q > right_q) || (top_q > bot_q);
    status_o.c_at_right    = (c_q == right_q);
    status_o.r_past_bottom = (r_q > bot_q);
    status_o.r_at_bottom   = (r_q == bot_q);
    status_o.thin          = !((left_q < right_q) && (top_q < bot_q));
    status_o.c_at_left     = (c_q == left_q);
    status_o.r_at_top      = (r_q == top_q);
    status_o.r_next_top    = (r_q == (top_q + ONE_S));
  end

  // Result count: mark the last of rows*cols results
  always_comb begin
    emit_cnt_d = emit_cnt_q;
    if (ctrl_i.op == OP_INIT) begin
      emit_cnt_d = '0;
    end else if (ctrl_i.emit) begin
      emit_cnt_d = emit_cnt_q + CNT_W'(1);
    end
    last = (emit_cnt_q == (dims_i.total - CNT_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_cnt_q <= '0;
    end else begin
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // Store address r*cols + c
  always_comb begin
    prod      = CNT_W'(r_q[IDX_W-1:0]) * CNT_W'(dims_i.cols);
    addr_full = prod + CNT_W'(c_q[IDX_W-1:0]);
    addr      = addr_full[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit;
      final_q <= ctrl_i.emit & last;
    end
  end

  assign value_o     = rd_q;
  assign final_res_o = final_q;
  assign valid_o     = valid_q;

  `ASSERT_RST(a_walk_in_ring, ctrl_i.emit |-> (r_q >= top_q && r_q <= bot_q && c_q >= left_q && c_q <= right_q), "spiral pointer left the current ring")
  `ASSERT_RST(a_go_starts_run, status_o.go |=> busy_i, "completed load did not start a run")
  `ASSERT_RST(a_no_wr_on_read, wr_en |-> !ctrl_i.emit, "store written during a run")

endmodule

### rtl/spiral_order_scan.sv
// Top level of the spiral scan: configuration registers, dimension clamping,
// sequencer and datapath. Depends on sos_pkg, sos_seq, sos_dp.
//
// Usage: load a matrix of row_count x col_count 32-bit elements in row-major
// order, one transaction per cycle, by raising start with element_i while
// busy is low. The transaction that completes the matrix starts a run: busy
// rises on the next cycle and the elements come out in clockwise spiral
// order on value_o, each for one cycle with valid_o high; final_res_o marks
// the last one. The first result follows the RING step, the first TOP step
// and the registered store read. A run of R x C elements has R*C result
// steps plus three or four check steps per ring and one more ring check that
// drops busy; the microcode sequencer drives one store read per result step.
// The receiver cannot stall: results are not held. Write row_count (index 0)
// and col_count (index 1) through cfg_we_i only while busy is low and no load
// is under way; 0 is taken as 1 and values above the maximum as the maximum.
// Reset clears the load count and sets both dimensions to 1; store contents
// stay undefined until loaded.
`include "assert_macros.svh"

module spiral_order_scan #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         element_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [sos_pkg::DIM_W-1:0]  cfg_data_i,
  output logic signed [31:0]         value_o,
  output logic                       final_res_o,
  output logic                       valid_o
);
  import sos_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_COLS);

  logic [DIM_W-1:0] row_cnt_q, col_cnt_q;
  logic [DIM_W-1:0] rows, cols;
  logic [2*DIM_W-1:0] area;
  sos_dims_t   dims;
  sos_ctrl_t   ctrl;
  sos_status_t status;

  // Configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= DIM_W'(1);
      col_cnt_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: row_cnt_q <= cfg_data_i;
        CFG_COLS: col_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to 1..max and form the element count
  always_comb begin
    if (row_cnt_q == '0) begin
      rows = DIM_W'(1);
    end else if (row_cnt_q > MAX_R) begin
      rows = MAX_R;
    end else begin
      rows = row_cnt_q;
    end
    if (col_cnt_q == '0) begin
      cols = DIM_W'(1);
    end else if (col_cnt_q > MAX_C) begin
      cols = MAX_C;
    end else begin
      cols = col_cnt_q;
    end
    area       = rows * cols;
    dims.rows  = rows;
    dims.cols  = cols;
    dims.total = area[CNT_W-1:0];
  end

  sos_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  sos_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .element_i   (element_i),
    .dims_i      (dims),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .value_o     (value_o),
    .final_res_o (final_res_o),
    .valid_o     (valid_o)
  );

  `ASSERT_CLK(a_final_has_valid, final_res_o |-> valid_o, "final flag without a result")
  `ASSERT_RST(a_busy_from_start, $rose(busy) |-> $past(start), "run began without a transaction")
  `ASSERT_RST(a_drain_before_idle, $fell(busy) |-> !valid_o, "busy dropped with a result in flight")

endmodule
